>>> src/gpc_pkg.sv
// shared constants and register codes for the grid path counter
`default_nettype none

package gpc_pkg;

  localparam int DEF_MAX_COLS   = 128;
  localparam int DEF_COUNT_BITS = 32;

  localparam int OUT_W       = 32;  // width of path_count on the port
  localparam int COLS_REG_W  = 8;   // width of grid_cols
  localparam int ROWS_REG_W  = 16;  // width of grid_rows
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS = 8'd0,
    REG_GRID_ROWS = 8'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> src/gpc_if.sv
// channel interfaces: cell input, count output, register writes
`default_nettype none

interface gpc_cell_if;
  logic valid;
  logic ready;
  logic blocked;

  modport source (output valid, output blocked, input ready);
  modport sink   (input valid, input blocked, output ready);
endinterface

interface gpc_count_if
  import gpc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] path_count;
  logic             saturated;
  logic             grid_done;

  modport source (output valid, output path_count, output saturated, output grid_done,
                  input ready);
  modport sink   (input valid, input path_count, input saturated, input grid_done,
                  output ready);
endinterface

interface gpc_cfg_if
  import gpc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/gpc_cell.sv
// one stage of the row buffer chain: loads a new count at the entry point, else shifts
`default_nettype none

module gpc_cell
  import gpc_pkg::*;
#(
  parameter int POS        = 0,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int IDX_W      = 7
) (
  input  wire logic                  clk,
  input  wire logic                  shift,
  input  wire logic [IDX_W-1:0]      entry,
  input  wire logic [COUNT_BITS-1:0] new_count,
  input  wire logic [COUNT_BITS-1:0] prev_count,
  output      logic [COUNT_BITS-1:0] count
);

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

  always_ff @(posedge clk) begin
    if (shift) begin
      count <= (entry == MY_POS) ? new_count : prev_count;
    end
  end

endmodule

`default_nettype wire

>>> src/gpc_row_chain.sv
// row of counts held as a chain of cells; a count leaves the tail one grid row after entry
`default_nettype none

module gpc_row_chain
  import gpc_pkg::*;
#(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int IDX_W      = 7
) (
  input  wire logic                  clk,
  input  wire logic                  shift,
  input  wire logic [IDX_W-1:0]      entry,
  input  wire logic [COUNT_BITS-1:0] new_count,
  output      logic [COUNT_BITS-1:0] tail_count
);

  logic [COUNT_BITS-1:0] stage [MAX_COLS];

  for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
    logic [COUNT_BITS-1:0] prev;
    if (k == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = stage[k-1];
    end

    gpc_cell #(
      .POS        (k),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W)
    ) u_cell (
      .clk        (clk),
      .shift      (shift),
      .entry      (entry),
      .new_count  (new_count),
      .prev_count (prev),
      .count      (stage[k])
    );
  end

  assign tail_count = stage[MAX_COLS-1];

endmodule

`default_nettype wire

>>> src/grid_path_count_with_obstacles.sv
// top level: path counter over a streamed grid with obstacles
//
//   channel  dir  payload                               transaction when
//   cells    in   blocked                               valid & ready
//   counts   out  path_count, saturated, grid_done      valid & ready
//   cfg      in   index (0 grid_cols, 1 grid_rows), data  valid & ready
//
// one cell per cycle; its count is registered and shown the cycle after acceptance
// the row above lives in a chain of MAX_COLS cells; a new count enters at
// MAX_COLS - cols and reaches the tail exactly one row later
// cells stalls only while a result waits and counts is not ready
// cfg is always ready; a write to a known register restarts the grid at the origin
// rst is synchronous; the row chain itself is not cleared (row 0 ignores it)
`default_nettype none

module grid_path_count_with_obstacles
  import gpc_pkg::*;
#(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst,
  gpc_cell_if.sink    cells,
  gpc_count_if.source counts,
  gpc_cfg_if.sink     cfg
);

  localparam int COL_W = $clog2(MAX_COLS + 1);
  localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CMP_W = (COL_W > COLS_REG_W) ? COL_W : COLS_REG_W;

  // configuration, kept in its effective form
  logic [COL_W-1:0]      cols_eff;
  logic [ROWS_REG_W-1:0] rows_eff;
  logic [IDX_W-1:0]      entry;

  logic [COUNT_BITS-1:0] left_count;
  logic [COL_W-1:0]      col_idx;
  logic [ROWS_REG_W-1:0] row_idx;

  logic                  out_valid;
  logic [COUNT_BITS-1:0] out_count;
  logic                  out_done;

  logic                  in_take;
  logic                  cfg_take;
  logic [COUNT_BITS-1:0] tail_count;

  logic [COL_W-1:0]      c;
  logic [ROWS_REG_W-1:0] r;
  logic [COUNT_BITS-1:0] up;
  logic [COUNT_BITS-1:0] left;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] cnt;
  logic                  last_col;
  logic                  done;

  logic [CMP_W-1:0]      cols_raw;
  logic [COL_W-1:0]      cols_next;
  logic [COL_W-1:0]      entry_wide;
  logic [ROWS_REG_W-1:0] rows_next;

  assign cfg.ready   = 1'b1;
  assign cfg_take    = cfg.valid;
  assign cells.ready = !out_valid || counts.ready;
  assign in_take     = cells.valid && cells.ready;

  // register decode: clamp the column count into 1..MAX_COLS, rows zero acts as one
  always_comb begin
    cols_raw = CMP_W'(cfg.data[COLS_REG_W-1:0]);
    if (cols_raw == '0) begin
      cols_next = COL_W'(1);
    end else if (cols_raw > CMP_W'(MAX_COLS)) begin
      cols_next = COL_W'(MAX_COLS);
    end else begin
      cols_next = cols_raw[COL_W-1:0];
    end
    entry_wide = COL_W'(MAX_COLS) - cols_next;
    rows_next  = (cfg.data == '0) ? ROWS_REG_W'(1) : cfg.data[ROWS_REG_W-1:0];
  end

  // count for the current cell
  always_comb begin
    c        = (col_idx >= cols_eff) ? '0 : col_idx;
    r        = (row_idx >= rows_eff) ? '0 : row_idx;
    up       = (r == '0) ? '0 : tail_count;
    left     = (c == '0) ? '0 : left_count;
    sum      = {1'b0, up} + {1'b0, left};
    if (cells.blocked) begin
      cnt = '0;
    end else if (r == '0 && c == '0) begin
      cnt = COUNT_BITS'(1);
    end else if (sum[COUNT_BITS]) begin
      cnt = '1;
    end else begin
      cnt = sum[COUNT_BITS-1:0];
    end
    last_col = (c == cols_eff - COL_W'(1));
    done     = last_col && (r == rows_eff - ROWS_REG_W'(1));
  end

  gpc_row_chain #(
    .MAX_COLS   (MAX_COLS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_row_chain (
    .clk        (clk),
    .shift      (in_take),
    .entry      (entry),
    .new_count  (cnt),
    .tail_count (tail_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_eff   <= COL_W'(MAX_COLS);
      entry      <= '0;
      rows_eff   <= ROWS_REG_W'(1);
      left_count <= '0;
      col_idx    <= '0;
      row_idx    <= '0;
    end else if (cfg_take) begin
      unique case (cfg.index)
        REG_GRID_COLS: begin
          cols_eff <= cols_next;
          entry    <= entry_wide[IDX_W-1:0];
        end
        REG_GRID_ROWS: begin
          rows_eff <= rows_next;
        end
        default: begin
        end
      endcase
      if (cfg.index == REG_GRID_COLS || cfg.index == REG_GRID_ROWS) begin
        left_count <= '0;
        col_idx    <= '0;
        row_idx    <= '0;
      end
    end else if (in_take) begin
      if (last_col) begin
        left_count <= '0;
        col_idx    <= '0;
        row_idx    <= done ? '0 : r + ROWS_REG_W'(1);
      end else begin
        left_count <= cnt;
        col_idx    <= c + COL_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (counts.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_count <= cnt;
      out_done  <= done;
    end
  end

  if (COUNT_BITS >= OUT_W) begin : g_out_narrow
    assign counts.path_count = out_count[OUT_W-1:0];
  end else begin : g_out_wide
    assign counts.path_count = {{(OUT_W-COUNT_BITS){1'b0}}, out_count};
  end

  assign counts.valid     = out_valid;
  assign counts.saturated = &out_count;
  assign counts.grid_done = out_done;

endmodule

`default_nettype wire

>>> tb/sv/tb_grid_path_count_with_obstacles.sv
// self-checking bench for the grid path counter: streamed grids against a cell-by-cell predictor
module tb_grid_path_count_with_obstacles;
  import gpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int                 ITEM_TARGET     = 1900;
  localparam int                 HOLD_OFF_CYCLES = 200;
  localparam int                 QUIET_LIMIT     = 4000;
  localparam int                 PRINT_LIMIT     = 50;
  localparam logic [OUT_W-1:0]   COUNT_CAP       = '1;

  typedef struct packed {
    logic [OUT_W-1:0] path_count;
    logic             saturated;
    logic             grid_done;
  } path_result_t;

  logic clk;
  logic rst;

  gpc_cell_if  cell_ch ();
  gpc_count_if count_ch ();
  gpc_cfg_if   cfg_ch ();

  grid_path_count_with_obstacles dut (
    .clk    (clk),
    .rst    (rst),
    .cells  (cell_ch),
    .counts (count_ch),
    .cfg    (cfg_ch)
  );

  // predictor state
  logic [COLS_REG_W-1:0] grid_cols_reg;
  logic [ROWS_REG_W-1:0] grid_rows_reg;
  logic [OUT_W-1:0]      above_cnt [DEF_MAX_COLS];
  logic [OUT_W-1:0]      left_cnt;
  int unsigned           col_idx;
  int unsigned           row_idx;

  path_result_t pending_counts [$];
  int           mismatch_count = 0;
  int           cells_sent     = 0;
  int           quiet_cycles   = 0;
  int           tx_idle_pct    = 19;
  int           rx_idle_pct    = 19;
  bit           rx_hold_req    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_cols();
    if (grid_cols_reg == 0) return 1;
    if (grid_cols_reg > DEF_MAX_COLS) return DEF_MAX_COLS;
    return 32'(grid_cols_reg);
  endfunction

  function automatic int unsigned eff_rows();
    if (grid_rows_reg == 0) return 1;
    return 32'(grid_rows_reg);
  endfunction

  function automatic void restart_grid();
    left_cnt = '0;
    col_idx  = 0;
    row_idx  = 0;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_GRID_COLS: begin
        grid_cols_reg = val[COLS_REG_W-1:0];
        restart_grid();
      end
      REG_GRID_ROWS: begin
        grid_rows_reg = val[ROWS_REG_W-1:0];
        restart_grid();
      end
      default: ;  // unknown index leaves everything alone
    endcase
  endfunction

  function automatic path_result_t count_next_cell(input logic blk);
    int unsigned    nc;
    int unsigned    nr;
    int unsigned    c;
    int unsigned    r;
    logic [OUT_W-1:0] up;
    logic [OUT_W-1:0] lf;
    logic [OUT_W-1:0] cnt;
    logic [OUT_W:0]   sum;
    path_result_t   res;
    nc = eff_cols();
    nr = eff_rows();
    if (col_idx >= nc) col_idx = 0;
    if (row_idx >= nr) row_idx = 0;
    c   = col_idx;
    r   = row_idx;
    up  = (r == 0) ? '0 : above_cnt[c];
    lf  = (c == 0) ? '0 : left_cnt;
    sum = {1'b0, up} + {1'b0, lf};
    if (blk) cnt = '0;
    else if (r == 0 && c == 0) cnt = 1;
    else if (sum[OUT_W]) cnt = COUNT_CAP;
    else cnt = sum[OUT_W-1:0];
    above_cnt[c]   = cnt;
    left_cnt       = cnt;
    res.path_count = cnt;
    res.saturated  = (cnt == COUNT_CAP);
    res.grid_done  = (c == nc - 1) && (r == nr - 1);
    if (c == nc - 1) begin
      col_idx  = 0;
      left_cnt = '0;
      row_idx  = res.grid_done ? 0 : r + 1;
    end else begin
      col_idx = c + 1;
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    // past the print limit mismatches are counted only
    if (mismatch_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // count sink with random stalls and an occasional long hold-off
  initial begin : count_sink
    count_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        count_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      count_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : count_check
    path_result_t want;
    if (!rst && count_ch.valid && count_ch.ready) begin
      if (pending_counts.size() == 0) begin
        flag_mismatch($sformatf("unexpected count %0d", count_ch.path_count));
      end else begin
        want = pending_counts.pop_front();
        if (count_ch.path_count !== want.path_count)
          flag_mismatch($sformatf("path_count %0d, want %0d",
                                  count_ch.path_count, want.path_count));
        if (count_ch.saturated !== want.saturated)
          flag_mismatch($sformatf("saturated %b, want %b",
                                  count_ch.saturated, want.saturated));
        if (count_ch.grid_done !== want.grid_done)
          flag_mismatch($sformatf("grid_done %b, want %b",
                                  count_ch.grid_done, want.grid_done));
      end
    end
  end

  always @(posedge clk) begin
    if ((cell_ch.valid && cell_ch.ready) || (count_ch.valid && count_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  task automatic push_cell(input logic blk);
    if ($urandom_range(99) < tx_idle_pct) begin
      cell_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cell_ch.valid   <= 1'b1;
    cell_ch.blocked <= blk;
    do @(posedge clk); while (!cell_ch.ready);
    pending_counts.push_back(count_next_cell(blk));
    cells_sent++;
  endtask

  task automatic run_cells(input int n, input int blk_pct);
    for (int k = 0; k < n; k++) push_cell($urandom_range(99) < blk_pct);
  endtask

  // stop sending and wait for every outstanding count
  task automatic drain();
    cell_ch.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input bit more);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg_write(idx, val);
    if (!more) cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_grid(input logic [CFG_DATA_W-1:0] cols_val,
                          input logic [CFG_DATA_W-1:0] rows_val);
    drain();
    write_reg(REG_GRID_COLS, cols_val, 1'b1);
    write_reg(REG_GRID_ROWS, rows_val, 1'b0);
  endtask

  // a few cells of the 128 x 1 reset grid, cut short by the next write
  task automatic test_reset_config();
    push_cell(1'b0);
    push_cell(1'b1);
    push_cell(1'b0);
    push_cell(1'b0);
  endtask

  // zero sizes act as one, a single column, a single row
  task automatic test_degenerate_sizes();
    set_grid(16'h0000, 16'h0000);
    push_cell(1'b0);
    push_cell(1'b1);
    push_cell(1'b0);
    set_grid(16'hFF01, 16'd3);
    push_cell(1'b0);
    push_cell(1'b1);
    push_cell(1'b0);
    set_grid(16'd4, 16'd1);
    push_cell(1'b0);
    push_cell(1'b0);
    push_cell(1'b1);
    push_cell(1'b0);
  endtask

  // writes to unknown indexes must not restart the grid
  task automatic test_unknown_index();
    set_grid(16'd3, 16'd3);
    for (int k = 0; k < 4; k++) push_cell(1'b0);
    drain();
    write_reg(8'hFF, 16'hFFFF, 1'b1);
    write_reg(8'h02, 16'h0001, 1'b0);
    for (int k = 4; k < 9; k++) push_cell(k == 4);
  endtask

  // open 20 x 20 grid runs past the cap, with no idling on either side
  task automatic test_saturation();
    set_grid(16'd20, 16'd20);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_cells(400, 0);
    drain();
    tx_idle_pct = 19;
    rx_idle_pct = 19;
  endtask

  task automatic test_backpressure();
    set_grid(16'd8, 16'd6);
    rx_hold_req = 1'b1;
    run_cells(48, 25);
    run_cells(20, 25);
    drain();
    run_cells(28, 25);
  endtask

  task automatic test_random_grids();
    logic [CFG_DATA_W-1:0] cols_val;
    logic [CFG_DATA_W-1:0] rows_val;
    int                    total;
    int                    n;
    while (cells_sent < ITEM_TARGET) begin
      cols_val = {8'($urandom_range(255)), 8'($urandom_range(1, 16))};
      if ($urandom_range(99) < 10) begin
        case ($urandom_range(3))
          0: cols_val[7:0] = 8'h00;
          1: cols_val[7:0] = 8'hFF;
          2: cols_val[7:0] = 8'h80;
          default: cols_val[7:0] = 8'h81;
        endcase
      end
      rows_val = 16'($urandom_range(0, 9));
      if ($urandom_range(15) == 0) rows_val = 16'hFFFF;
      set_grid(cols_val, rows_val);
      if ($urandom_range(4) == 0) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 19;
        rx_idle_pct = 19;
      end
      total = eff_cols() * eff_rows();
      n     = total * $urandom_range(1, 2);
      // huge grids and some ordinary ones stop part-way
      if (n > 400 || $urandom_range(7) == 0)
        n = $urandom_range(1, (total < 400) ? total : 400);
      run_cells(n, $urandom_range(0, 45));
    end
  endtask

  initial begin : stimulus
    rst             <= 1'b1;
    cell_ch.valid   <= 1'b0;
    cell_ch.blocked <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_GRID_COLS;
    cfg_ch.data     <= '0;
    grid_cols_reg = COLS_REG_W'(DEF_MAX_COLS);
    grid_rows_reg = ROWS_REG_W'(1);
    for (int k = 0; k < DEF_MAX_COLS; k++) above_cnt[k] = '0;
    restart_grid();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_degenerate_sizes();
    test_unknown_index();
    test_saturation();
    test_backpressure();
    test_random_grids();

    drain();
    repeat (8) @(posedge clk);
    if (pending_counts.size() != 0)
      flag_mismatch($sformatf("%0d counts never arrived", pending_counts.size()));
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
